@@ hw/rtl/lwsm_pkg.sv @@
// Package for the latency window statistics monitor.
// Holds sizes, widths and the sequencer state type; no dependencies.
package lwsm_pkg;
  localparam int MaxWindow = 128;
  localparam int TimeWidth = 48;
  localparam int PtrW = $clog2(MaxWindow);
  localparam int CntW = $clog2(MaxWindow + 1);
  localparam int SumW = 32 + CntW;
  localparam logic [7:0] WinReset = 8'd100;
  localparam logic [TimeWidth+20:0] RateNum = (TimeWidth+21)'(64'd1000000 << 16);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_DIV, ST_RATE, ST_SCALE, ST_OUT
  } lwsm_state_t;

  typedef struct packed {
    logic skipped;
    logic signed [31:0] delay_now;
    logic signed [31:0] delay_mean;
    logic signed [31:0] delay_max;
    logic signed [31:0] delay_min;
    logic [7:0] window_count;
    logic [31:0] rate_avg;
    logic [31:0] frames_total;
  } lwsm_result_t;
endpackage

@@ hw/rtl/lwsm_if.sv @@
// Channel interfaces for the monitor: input, result and configuration.
// Depends on lwsm_pkg.
interface lwsm_in_if;
  logic valid;
  logic ready;
  logic [lwsm_pkg::TimeWidth-1:0] pub_stamp;
  logic [lwsm_pkg::TimeWidth-1:0] rcv_stamp;
  modport source (output valid, pub_stamp, rcv_stamp, input ready);
  modport sink (input valid, pub_stamp, rcv_stamp, output ready);
endinterface

interface lwsm_out_if;
  logic valid;
  logic ready;
  logic skipped;
  logic signed [31:0] delay_now;
  logic signed [31:0] delay_mean;
  logic signed [31:0] delay_max;
  logic signed [31:0] delay_min;
  logic [7:0] window_count;
  logic [31:0] rate_avg;
  logic [31:0] frames_total;
  modport source (output valid, skipped, delay_now, delay_mean, delay_max, delay_min,
                  window_count, rate_avg, frames_total, input ready);
  modport sink (input valid, skipped, delay_now, delay_mean, delay_max, delay_min,
                window_count, rate_avg, frames_total, output ready);
endinterface

interface lwsm_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/lwsm_divider.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
// Depends on lwsm_pkg for the operand width.
module lwsm_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [lwsm_pkg::TimeWidth+20:0] dividend,
  input  logic [lwsm_pkg::TimeWidth+20:0] divisor,
  output logic busy,
  output logic [lwsm_pkg::TimeWidth+20:0] quotient
);
  localparam int W = lwsm_pkg::TimeWidth + 21;
  localparam int BW = $clog2(W + 1);
  logic [W-1:0] rem, dvs;
  logic [BW-1:0] bits;
  logic [W:0] trial;

  assign trial = {rem, quotient[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      bits <= '0;
    end else if (start) begin
      busy <= 1'b1;
      bits <= BW'(W);
    end else if (busy) begin
      bits <= bits - 1'b1;
      if (bits == BW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quotient <= {quotient[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quotient[W-1]};
        quotient <= {quotient[W-2:0], 1'b0};
      end
    end
  end
endmodule

@@ hw/rtl/latency_window_stats_monitor.sv @@
// Top level of the latency window statistics monitor.
// Depends on lwsm_pkg, the lwsm interfaces and lwsm_divider.
// A frame's request is taken in idle, and its result is built in the states that follow:
// the delay ring, a memory with one write and one read port, is scanned one entry a cycle
// for sum, min and max, the mean and then the rate pass through a shared bit-serial
// divider, and a shift-add step takes a tenth of the rate sum before the output state.
// Without a rate update (no earlier arrival or gap not positive) the rate division and the
// shift-add step are skipped. A skipped frame goes from idle straight to the output state.
// The next request is taken only after the result is accepted. No clearing pass after reset.
module latency_window_stats_monitor (
  input logic clk,
  input logic rst,
  lwsm_in_if.sink   in_req,
  lwsm_out_if.source out_res,
  lwsm_cfg_if.sink  cfg
);
  localparam int PW = lwsm_pkg::PtrW;
  localparam int CW = lwsm_pkg::CntW;
  localparam int SW = lwsm_pkg::SumW;
  localparam int TW = lwsm_pkg::TimeWidth;
  localparam int DW = TW + 21;

  logic signed [31:0] ring [lwsm_pkg::MaxWindow];
  logic signed [31:0] rd_data;
  logic [PW-1:0] wr_ptr, rd_addr;
  logic [CW-1:0] fill, n, scan_cnt;
  logic [7:0] win_size;
  logic signed [SW-1:0] sum;
  logic signed [31:0] mx, mn, dly, mean_q;
  logic [TW-1:0] last_arr, rcv;
  logic [31:0] rate, frames;
  logic rate_upd, rd_valid, skip;
  lwsm_pkg::lwsm_state_t state, state_next;
  lwsm_pkg::lwsm_result_t res;

  logic div_start, div_busy, div_mean, div_go;
  logic [DW-1:0] div_a, div_b, div_q;
  logic sum_neg;
  logic [SW-1:0] sum_mag;

  lwsm_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(div_q)
  );

  assign cfg.ready = 1'b1;
  assign in_req.ready = (state == lwsm_pkg::ST_IDLE) && !out_res.valid;

  logic [TW:0] dpos, dneg;
  logic signed [31:0] d_sat;
  logic [CW-1:0] fill_inc, eff;
  always_comb begin
    dpos = {1'b0, in_req.rcv_stamp} - {1'b0, in_req.pub_stamp};
    dneg = {1'b0, in_req.pub_stamp} - {1'b0, in_req.rcv_stamp};
    if (!dpos[TW]) d_sat = (dpos[TW-1:0] > TW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : dpos[31:0];
    else d_sat = (dneg[TW-1:0] >= TW'(33'h80000000)) ? 32'sh80000000 : -dneg[31:0];
    fill_inc = (fill < CW'(lwsm_pkg::MaxWindow)) ? fill + 1'b1 : fill;
    if (win_size == 8'd0) eff = CW'(1);
    else if ({1'b0, win_size} > 9'(lwsm_pkg::MaxWindow)) eff = CW'(lwsm_pkg::MaxWindow);
    else eff = CW'(win_size);
  end

  logic [2:0] scl;

  always_comb begin
    state_next = state;
    unique case (state)
      lwsm_pkg::ST_IDLE: begin
        if (in_req.valid && in_req.ready)
          state_next = (in_req.pub_stamp == '0) ? lwsm_pkg::ST_OUT : lwsm_pkg::ST_SCAN;
      end
      lwsm_pkg::ST_SCAN: if (scan_cnt == CW'(1)) state_next = lwsm_pkg::ST_DRAIN;
      lwsm_pkg::ST_DRAIN: state_next = lwsm_pkg::ST_DIV;
      lwsm_pkg::ST_DIV: if (!div_start && !div_busy)
        state_next = rate_upd ? lwsm_pkg::ST_RATE : lwsm_pkg::ST_OUT;
      lwsm_pkg::ST_RATE: if (!div_start && !div_busy) state_next = lwsm_pkg::ST_SCALE;
      lwsm_pkg::ST_SCALE: if (scl == 3'd6) state_next = lwsm_pkg::ST_OUT;
      lwsm_pkg::ST_OUT: if (!out_res.valid) state_next = lwsm_pkg::ST_IDLE;
      default: state_next = lwsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sum_neg = sum[SW-1];
    sum_mag = sum_neg ? -sum : sum;
    div_a = div_mean ? DW'(sum_mag) : lwsm_pkg::RateNum;
    div_b = div_mean ? DW'(n) : DW'(rcv - last_arr);
    div_go = (state == lwsm_pkg::ST_DRAIN) ||
             ((state == lwsm_pkg::ST_DIV) && !div_start && !div_busy && rate_upd);
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready && in_req.pub_stamp != '0)
      ring[wr_ptr] <= d_sat;
    rd_data <= ring[rd_addr];
  end

  logic [35:0] r9;
  logic [36:0] rsum;
  logic [36:0] rs, rq, rrem, rnew;
  always_comb begin
    r9 = {4'd0, rate} * 36'd9;
    rsum = {1'b0, r9} + 37'(div_q);
    rrem = rs - {rq[33:0], 3'b000} - {rq[35:0], 1'b0};
    rnew = rq + 37'(rrem > 37'd9);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwsm_pkg::ST_IDLE;
      win_size <= lwsm_pkg::WinReset;
      wr_ptr <= '0;
      fill <= '0;
      last_arr <= '0;
      rate <= '0;
      frames <= '0;
      out_res.valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      state <= state_next;
      div_start <= div_go;
      if (cfg.valid) win_size <= cfg.data;
      if (out_res.valid && out_res.ready) out_res.valid <= 1'b0;
      unique case (state)
        lwsm_pkg::ST_IDLE: begin
          if (in_req.valid && in_req.ready) begin
            skip <= in_req.pub_stamp == '0;
            if (in_req.pub_stamp != '0) begin
              dly <= d_sat;
              wr_ptr <= wr_ptr + 1'b1;
              fill <= fill_inc;
              n <= (fill_inc < eff) ? fill_inc : eff;
              scan_cnt <= (fill_inc < eff) ? fill_inc : eff;
              rd_addr <= wr_ptr;
              rcv <= in_req.rcv_stamp;
              rate_upd <= (last_arr != '0) && (in_req.rcv_stamp > last_arr);
              sum <= '0;
              mx <= 32'sh80000000;
              mn <= 32'sh7FFFFFFF;
              rd_valid <= 1'b0;
            end
          end
        end
        lwsm_pkg::ST_SCAN, lwsm_pkg::ST_DRAIN: begin
          if (state == lwsm_pkg::ST_SCAN) begin
            scan_cnt <= scan_cnt - 1'b1;
            rd_addr <= rd_addr - 1'b1;
          end
          rd_valid <= (state == lwsm_pkg::ST_SCAN);
          if (rd_valid) begin
            sum <= sum + SW'(rd_data);
            if (rd_data > mx) mx <= rd_data;
            if (rd_data < mn) mn <= rd_data;
          end
          if (state == lwsm_pkg::ST_DRAIN) div_mean <= 1'b1;
        end
        lwsm_pkg::ST_DIV: begin
          if (!div_start && !div_busy) begin
            mean_q <= sum_neg ? -div_q[31:0] : div_q[31:0];
            div_mean <= 1'b0;
          end
        end
        lwsm_pkg::ST_RATE: begin
          if (!div_start && !div_busy) begin
            rs <= rsum;
            scl <= '0;
          end
        end
        lwsm_pkg::ST_SCALE: begin
          scl <= scl + 1'b1;
          unique case (scl)
            3'd0: rq <= (rs >> 1) + (rs >> 2);
            3'd1: rq <= rq + (rq >> 4);
            3'd2: rq <= rq + (rq >> 8);
            3'd3: rq <= rq + (rq >> 16);
            3'd4: rq <= rq + (rq >> 32);
            3'd5: rq <= rq >> 3;
            default: rate <= (rnew > 37'hFFFFFFFF) ? 32'hFFFFFFFF : rnew[31:0];
          endcase
        end
        lwsm_pkg::ST_OUT: begin
          if (!out_res.valid) begin
            out_res.valid <= 1'b1;
            if (skip) res <= '{skipped: 1'b1, default: '0};
            else begin
              last_arr <= rcv;
              frames <= frames + 1'b1;
              res <= '{skipped: 1'b0, delay_now: dly, delay_mean: mean_q,
                       delay_max: mx, delay_min: mn, window_count: 8'(n),
                       rate_avg: rate, frames_total: frames + 1'b1};
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_res.skipped = res.skipped;
  assign out_res.delay_now = res.delay_now;
  assign out_res.delay_mean = res.delay_mean;
  assign out_res.delay_max = res.delay_max;
  assign out_res.delay_min = res.delay_min;
  assign out_res.window_count = res.window_count;
  assign out_res.rate_avg = res.rate_avg;
  assign out_res.frames_total = res.frames_total;
endmodule

@@ sim/lwsm_tb_if.sv @@
// Testbench-side notes: the channel interfaces come from hw/rtl/lwsm_if.sv.
// This file holds the frame table row record used by the testbench; depends on lwsm_pkg.
package lwsm_tb_pkg;
  import lwsm_pkg::*;

  typedef struct {
    logic [TimeWidth-1:0] pub;
    logic [TimeWidth-1:0] rcv;
    bit check_fixed;
    lwsm_result_t fixed_res;
  } frame_row_t;
endpackage

@@ sim/testbench.sv @@
// Testbench for latency_window_stats_monitor: directed table then random frames,
// checked against an in-bench window and rate predictor. Depends on lwsm_pkg,
// the lwsm interfaces and lwsm_tb_pkg.
module testbench;
  import lwsm_pkg::*;
  import lwsm_tb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  lwsm_in_if in_req();
  lwsm_out_if out_res();
  lwsm_cfg_if cfg();

  latency_window_stats_monitor dut (.clk(clk), .rst(rst), .in_req(in_req.sink),
    .out_res(out_res.source), .cfg(cfg.sink));

  initial begin
    forever #6 clk = ~clk;
  end

  logic signed [31:0] ring [MaxWindow];
  int unsigned wptr, fill, win_reg;
  logic [TimeWidth-1:0] last_rcv;
  logic [31:0] rate_q, frame_cnt;
  lwsm_result_t expected_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit idle_ok = 1;
  bit hold_off = 0;
  int rcv_idle_pct = 26;
  int snd_idle_pct = 26;

  function automatic logic signed [31:0] clip_delay(logic [TimeWidth-1:0] p,
                                                     logic [TimeWidth-1:0] r);
    logic signed [TimeWidth:0] d;
    d = $signed({1'b0, r}) - $signed({1'b0, p});
    if (d > 2147483647) return 32'sh7fffffff;
    if (d < -64'sd2147483648) return 32'sh80000000;
    return d[31:0];
  endfunction

  function automatic lwsm_result_t predict_frame(logic [TimeWidth-1:0] p,
                                                 logic [TimeWidth-1:0] r);
    lwsm_result_t res;
    logic signed [31:0] d, mx, mn, v;
    longint sum;
    int unsigned eff, n;
    logic [63:0] gap, inst, nr;
    res = '0;
    if (p == 0) begin
      res.skipped = 1;
      return res;
    end
    d = clip_delay(p, r);
    ring[wptr] = d;
    wptr = (wptr + 1) % MaxWindow;
    if (fill < MaxWindow) fill++;
    eff = (win_reg == 0) ? 1 : win_reg;
    if (eff > MaxWindow) eff = MaxWindow;
    n = (fill < eff) ? fill : eff;
    sum = 0;
    mx = 32'sh80000000;
    mn = 32'sh7fffffff;
    for (int k = 0; k < n; k++) begin
      v = ring[(wptr + MaxWindow - 1 - k) % MaxWindow];
      sum += v;
      if (v > mx) mx = v;
      if (v < mn) mn = v;
    end
    if (last_rcv != 0 && r > last_rcv) begin
      gap = r - last_rcv;
      inst = (64'd1000000 << 16) / gap;
      nr = (64'(rate_q) * 9 + inst) / 10;
      rate_q = (nr > 64'hffffffff) ? 32'hffffffff : nr[31:0];
    end
    last_rcv = r;
    frame_cnt++;
    res.delay_now = d;
    res.delay_mean = 32'(sum / longint'(n));
    res.delay_max = mx;
    res.delay_min = mn;
    res.window_count = n[7:0];
    res.rate_avg = rate_q;
    res.frames_total = frame_cnt;
    return res;
  endfunction

  function automatic bit idle_now(int pct);
    return idle_ok && ($urandom_range(99) < pct);
  endfunction

  task automatic send_frame(logic [TimeWidth-1:0] p, logic [TimeWidth-1:0] r,
                            bit use_fixed, lwsm_result_t fixed);
    lwsm_result_t pred;
    while (idle_now(snd_idle_pct)) begin
      in_req.valid <= 0;
      @(posedge clk);
    end
    in_req.valid <= 1;
    in_req.pub_stamp <= p;
    in_req.rcv_stamp <= r;
    do @(posedge clk); while (!in_req.ready);
    pred = predict_frame(p, r);
    if (use_fixed && fixed != pred) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: %p vs %p", fixed, pred);
    end
    expected_q.insert(expected_q.size(), pred);
  endtask

  task automatic write_window(logic [7:0] w);
    in_req.valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg.valid <= 1;
    cfg.data <= w;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
    win_reg = w;
  endtask

  always @(posedge clk) begin
    lwsm_result_t got, want;
    if (!rst && out_res.valid && out_res.ready) begin
      got = '{out_res.skipped, out_res.delay_now, out_res.delay_mean, out_res.delay_max,
              out_res.delay_min, out_res.window_count, out_res.rate_avg,
              out_res.frames_total};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
    out_res.ready <= !rst && !hold_off && !idle_now(rcv_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [TimeWidth-1:0] rand_time();
    return TimeWidth'({$urandom(), $urandom()});
  endfunction

  frame_row_t table_rows[$];

  task automatic add_row(logic [TimeWidth-1:0] p, logic [TimeWidth-1:0] r, bit f,
                         lwsm_result_t e);
    frame_row_t row;
    row.pub = p;
    row.rcv = r;
    row.check_fixed = f;
    row.fixed_res = e;
    table_rows.insert(table_rows.size(), row);
  endtask

  initial begin
    lwsm_result_t skip_res, none;
    logic [TimeWidth-1:0] t, p;
    logic [7:0] sizes[5] = '{8'd1, 8'd0, 8'd255, 8'd128, 8'd7};
    int n;
    in_req.valid = 0;
    in_req.pub_stamp = 0;
    in_req.rcv_stamp = 0;
    cfg.valid = 0;
    cfg.data = 0;
    out_res.ready = 0;
    win_reg = WinReset;
    wptr = 0; fill = 0; last_rcv = 0; rate_q = 0; frame_cnt = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    skip_res = '0;
    skip_res.skipped = 1;
    none = '0;
    add_row(0, 48'h1234, 1, skip_res);
    add_row(48'd1000, 48'd1500, 1, '{0, 500, 500, 500, 500, 8'd1, 0, 1});
    add_row(48'd2000, 48'd1000, 0, none);
    add_row(48'd1, 48'hffffffffffff, 0, none);
    add_row(48'hffffffffffff, 48'd1, 0, none);
    add_row(48'd5, 48'd5, 0, none);
    add_row(0, 0, 1, skip_res);
    add_row(48'd10, 48'd0, 0, none);
    add_row(48'd10, 48'd1000, 0, none);
    add_row(48'd10, 48'd1000, 0, none);
    add_row(48'd10, 48'd1001, 0, none);
    add_row(48'h800000000000, 48'h80000000000f, 0, none);
    add_row(48'd100, 48'h80000063, 0, none);
    add_row(48'h80000064, 48'd100, 0, none);
    add_row(48'h80000063, 48'd100, 0, none);
    foreach (table_rows[i])
      send_frame(table_rows[i].pub, table_rows[i].rcv, table_rows[i].check_fixed,
                 table_rows[i].fixed_res);

    t = 48'd1000;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_window(sizes[ph - 1]);
      idle_ok = (ph != 2);
      n = (ph == 5) ? 100 : 100;
      for (int i = 0; i < n; i++) begin
        if (ph == 3 && i == 10) begin
          fork
            begin
              hold_off = 1;
              repeat (3000) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        case ($urandom_range(19))
          0: send_frame(0, rand_time(), 0, none);
          1: send_frame(rand_time(), rand_time(), 0, none);
          2: send_frame(rand_time(), 0, 0, none);
          default: begin
            t = t + TimeWidth'($urandom_range(40000, 1));
            if ($urandom_range(9) == 0) t = t - TimeWidth'($urandom_range(500));
            p = t - TimeWidth'($urandom_range(200000)) + TimeWidth'(1000);
            if (p == 0) p = 1;
            send_frame(p, t, 0, none);
          end
        endcase
      end
    end
    write_window(8'd100);

    while (expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
